/* src/axis_deadzone_power_curve_assert.svh */
// Assertion macros used by the axis shaping RTL.
`ifndef AXIS_DEADZONE_POWER_CURVE_ASSERT_SVH
`define AXIS_DEADZONE_POWER_CURVE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define AXDZ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("axis shaping check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define AXDZ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("axis shaping check failed");

`endif

/* src/axdz_pkg.sv */
// Package with widths, constants and register codes of the axis shaping block.
package axdz_pkg;

  // Field and datapath widths.
  localparam int AXIS_W    = 16;
  localparam int MAG_W     = 17;
  localparam int GAIN_W    = 16;
  localparam int PROD_W    = 31;
  localparam int FRAC_W    = 27;
  localparam int DZ_SHIFT  = 12;
  localparam int SCALE_W   = 15;
  localparam int EXP_IN_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Full-scale constants.
  localparam logic [MAG_W-1:0]   IN_FULL  = 17'd32768;
  localparam logic [SCALE_W-1:0] OUT_FULL = 15'd32767;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_ZONE = 2'd0,
    REG_GAIN      = 2'd1,
    REG_EXPONENT  = 2'd2
  } cfg_reg_t;

endpackage

/* src/axis_deadzone_power_curve.sv */
// Joystick axis shaper: dead zone, gain, clamp and integer power curve, fully pipelined.

// Takes one signed axis sample per cycle when not stalled and returns one shaped drive
// value per sample, in order. One stage forms the magnitude, one the gain product, one
// removes the dead zone and clamps, MAX_EXPONENT - 1 stages each hold one 27x27 multiply
// of the power chain, one scales to 32767 and one applies the sign and drives the output
// register. Throughput is one sample per clock; a stall on the output fills empty stages
// first, so the input stalls only once every stage holds an item.
// Configuration registers are written through the cfg port, which is always ready, and
// should be changed only while no sample is in flight.
module axis_deadzone_power_curve #(
  parameter int MAX_EXPONENT = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Sample input channel.
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [axdz_pkg::AXIS_W-1:0]     in_axis_value,
  // Result channel.
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [axdz_pkg::AXIS_W-1:0]     out_drive_value,
  // Configuration write channel.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [axdz_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [axdz_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import axdz_pkg::*;

  localparam int NC = MAX_EXPONENT;
  localparam int EW = $clog2(MAX_EXPONENT + 1);

  // Configuration registers.
  logic [AXIS_W-1:0]   dead_zone_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [EXP_IN_W-1:0] exponent_r;

  // Pipeline registers.
  logic              s1_valid_r;
  logic [MAG_W-1:0]  s1_mag_r;
  logic              s1_neg_r;
  logic              s2_valid_r;
  logic [PROD_W-1:0] s2_prod_r;
  logic              s2_neg_r;

  logic              ch_valid_r [NC];
  logic [FRAC_W-1:0] ch_u_r     [NC];
  logic [FRAC_W-1:0] ch_p_r     [NC];
  logic [EW-1:0]     ch_e_r     [NC];
  logic              ch_neg_r   [NC];
  logic              ch_zero_r  [NC];
  logic              ch_full_r  [NC];

  logic               sf_valid_r;
  logic [SCALE_W-1:0] sf_scaled_r;
  logic               sf_neg_r;
  logic               sf_zero_r;
  logic               sf_full_r;

  logic              out_valid_r;
  logic [AXIS_W-1:0] out_drive_r;

  // Per-stage ready: a stage takes new data when empty or when it drains downstream.
  logic out_rdy;
  logic sf_rdy;
  logic ch_rdy [NC];
  logic s2_rdy;
  logic s1_rdy;

  assign out_rdy = !out_valid_r || !out_stall;
  assign sf_rdy  = !sf_valid_r || out_rdy;

  for (genvar k = 0; k < NC; k++) begin : g_rdy
    if (k == NC - 1) begin : g_last
      assign ch_rdy[k] = !ch_valid_r[k] || sf_rdy;
    end else begin : g_mid
      assign ch_rdy[k] = !ch_valid_r[k] || ch_rdy[k+1];
    end
  end

  assign s2_rdy = !s2_valid_r || ch_rdy[0];
  assign s1_rdy = !s1_valid_r || s2_rdy;

  assign in_stall  = !s1_rdy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_drive_value = $signed(out_drive_r);

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r <= '0;
      gain_r      <= 16'd4096;
      exponent_r  <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEAD_ZONE: dead_zone_r <= cfg_data;
        REG_GAIN:      gain_r      <= cfg_data;
        REG_EXPONENT:  exponent_r  <= cfg_data[EXP_IN_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits of the fixed stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      sf_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_rdy)  s1_valid_r  <= in_valid;
      if (s2_rdy)  s2_valid_r  <= s1_valid_r;
      if (sf_rdy)  sf_valid_r  <= ch_valid_r[NC-1];
      if (out_rdy) out_valid_r <= sf_valid_r;
    end
  end

  // Stage 1: sign and magnitude; the most negative sample gives exactly 32768.
  logic [MAG_W-1:0] mag_raw;
  assign mag_raw = {1'b0, in_axis_value};

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_neg_r <= in_axis_value[AXIS_W-1];
      s1_mag_r <= in_axis_value[AXIS_W-1] ? (IN_FULL + IN_FULL - mag_raw) : mag_raw;
    end
  end

  // Stage 2: gain times magnitude, exact in Q.27.
  logic [GAIN_W+MAG_W-1:0] prod_w;
  assign prod_w = {{MAG_W{1'b0}}, gain_r} * {{GAIN_W{1'b0}}, s1_mag_r};

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_neg_r  <= s1_neg_r;
      s2_prod_r <= prod_w[PROD_W-1:0];
    end
  end

  // Stage 3: remove the dead zone, flag the clamped ends and fix the exponent.
  logic [PROD_W-1:0] dz_off;
  logic [PROD_W-1:0] diff;
  logic [EW-1:0]     e_clamp;

  assign dz_off = PROD_W'({dead_zone_r, {DZ_SHIFT{1'b0}}});
  assign diff   = s2_prod_r - dz_off;

  always_comb begin
    if (exponent_r == '0) begin
      e_clamp = EW'(1);
    end else if (32'(exponent_r) > MAX_EXPONENT) begin
      e_clamp = EW'(MAX_EXPONENT);
    end else begin
      e_clamp = EW'(exponent_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_valid_r[0] <= 1'b0;
    end else if (ch_rdy[0]) begin
      ch_valid_r[0] <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ch_rdy[0]) begin
      ch_neg_r[0]  <= s2_neg_r;
      ch_zero_r[0] <= (s2_prod_r <= dz_off);
      ch_full_r[0] <= |diff[PROD_W-1:FRAC_W];
      ch_u_r[0]    <= diff[FRAC_W-1:0];
      ch_p_r[0]    <= diff[FRAC_W-1:0];
      ch_e_r[0]    <= e_clamp;
    end
  end

  // Power chain: stage k multiplies by u once more while k is below the exponent.
  for (genvar k = 1; k < NC; k++) begin : g_pow
    logic [2*FRAC_W-1:0] mul;
    assign mul = {{FRAC_W{1'b0}}, ch_p_r[k-1]} * {{FRAC_W{1'b0}}, ch_u_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ch_valid_r[k] <= 1'b0;
      end else if (ch_rdy[k]) begin
        ch_valid_r[k] <= ch_valid_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ch_rdy[k]) begin
        ch_neg_r[k]  <= ch_neg_r[k-1];
        ch_zero_r[k] <= ch_zero_r[k-1];
        ch_full_r[k] <= ch_full_r[k-1];
        ch_u_r[k]    <= ch_u_r[k-1];
        ch_e_r[k]    <= ch_e_r[k-1];
        ch_p_r[k]    <= (EW'(k) < ch_e_r[k-1]) ? mul[2*FRAC_W-1:FRAC_W] : ch_p_r[k-1];
      end
    end
  end

  // Scale stage: p times 32767, truncated back from Q.27.
  logic [FRAC_W+SCALE_W-1:0] scl;
  assign scl = {{SCALE_W{1'b0}}, ch_p_r[NC-1]} * {{FRAC_W{1'b0}}, OUT_FULL};

  always_ff @(posedge clk) begin
    if (sf_rdy) begin
      sf_scaled_r <= scl[FRAC_W+SCALE_W-1:FRAC_W];
      sf_neg_r    <= ch_neg_r[NC-1];
      sf_zero_r   <= ch_zero_r[NC-1];
      sf_full_r   <= ch_full_r[NC-1];
    end
  end

  // Output stage: select zero, full scale or the curve, then apply the sign.
  logic [AXIS_W-1:0] mag_out;

  always_comb begin
    if (sf_zero_r) begin
      mag_out = '0;
    end else if (sf_full_r) begin
      mag_out = {1'b0, OUT_FULL};
    end else begin
      mag_out = {1'b0, sf_scaled_r};
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_drive_r <= sf_neg_r ? (AXIS_W'(0) - mag_out) : mag_out;
    end
  end

  // Checks on the output stage.
  `include "axis_deadzone_power_curve_assert.svh"

  // A positive sample beyond the full zone waits in the scale stage.
  logic sf_full_pos;
  assign sf_full_pos = sf_valid_r && !sf_zero_r && sf_full_r && !sf_neg_r;

  `AXDZ_ASSERT_SAME(a_no_min_code, out_valid_r, out_drive_r != {1'b1, {(AXIS_W-1){1'b0}}})
  `AXDZ_ASSERT_NEXT(a_dead_zone_zero, sf_valid_r && sf_zero_r && out_rdy, out_drive_r == '0)
  `AXDZ_ASSERT_NEXT(a_full_pos, sf_full_pos && out_rdy, out_drive_r == {1'b0, OUT_FULL})

endmodule

/* tb/axis_deadzone_power_curve_tb.sv */
// Self-checking testbench for the axis dead zone, gain and power curve shaper.
module axis_deadzone_power_curve_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import axdz_pkg::*;

  localparam int MAX_EXPONENT   = 8;
  localparam int PIPE_LATENCY   = MAX_EXPONENT + 4;
  localparam int SETTLE_CYCLES  = 2 * PIPE_LATENCY;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 60;
  localparam int REPORT_LIMIT   = 10;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [63:0] UNITY_Q27 = 64'd1 << FRAC_W;
  localparam logic signed [AXIS_W-1:0] AXIS_MAX = 16'sh7FFF;
  localparam logic signed [AXIS_W-1:0] AXIS_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [AXIS_W-1:0] in_axis_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [AXIS_W-1:0] out_drive_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the register file used by the curve predictor.
  logic [CFG_DATA_W-1:0] dz_shadow = 16'd0;
  logic [GAIN_W-1:0] gain_shadow = 16'd4096;
  logic [EXP_IN_W-1:0] exp_shadow = 4'd1;

  logic signed [AXIS_W-1:0] axis_pending_q[$];
  logic signed [AXIS_W-1:0] drive_expect_q[$];
  logic signed [AXIS_W-1:0] drive_want;

  int error_cnt = 0;
  int results_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int stall_span = 0;
  int stall_tick = 0;
  int idle_cycles = 0;
  logic hold_req = 1'b0;
  logic sender_hold = 1'b0;
  stall_mode_t stall_mode = STALL_NONE;

  axis_deadzone_power_curve #(
    .MAX_EXPONENT(MAX_EXPONENT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_axis_value(in_axis_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_drive_value(out_drive_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shaped drive value for one axis sample under the current register copy.
  function automatic logic signed [AXIS_W-1:0] shape_axis(input logic signed [AXIS_W-1:0] axis);
    int sx;
    int unsigned pow;
    logic [MAG_W-1:0] mag;
    logic [63:0] prod, offset, u, p, res;
    sx = int'(axis);
    mag = (sx < 0) ? MAG_W'(-sx) : MAG_W'(sx);
    prod = 64'(gain_shadow) * 64'(mag);
    offset = 64'(dz_shadow) << DZ_SHIFT;
    if (prod <= offset) begin
      res = '0;
    end else begin
      u = prod - offset;
      if (u >= UNITY_Q27) begin
        res = 64'(OUT_FULL);
      end else begin
        pow = 32'(exp_shadow);
        if (pow < 1) pow = 1;
        if (pow > MAX_EXPONENT) pow = MAX_EXPONENT;
        p = u;
        for (int k = 1; k < pow; k++) p = (p * u) >> FRAC_W;
        res = (p * 64'(OUT_FULL)) >> FRAC_W;
      end
    end
    return (sx < 0) ? -AXIS_W'(res) : AXIS_W'(res);
  endfunction

  // Random sample: mostly inside the curved band of the current setting, some anywhere.
  function automatic logic signed [AXIS_W-1:0] pick_axis();
    logic [63:0] lo, hi;
    int unsigned mag;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3 || gain_shadow == 0) return AXIS_W'($urandom);
    if (sel == 3) begin
      case ($urandom_range(0, 3))
        0: return AXIS_MAX;
        1: return AXIS_MIN;
        2: return -AXIS_MAX;
        default: return '0;
      endcase
    end
    lo = (64'(dz_shadow) << DZ_SHIFT) / gain_shadow;
    hi = ((64'(dz_shadow) << DZ_SHIFT) + UNITY_Q27) / gain_shadow + 1;
    if (lo > IN_FULL) lo = 64'(IN_FULL);
    if (hi > IN_FULL) hi = 64'(IN_FULL);
    mag = $urandom_range(32'(hi), 32'(lo));
    if ($urandom_range(0, 1) == 1) return AXIS_W'(-int'(mag));
    if (mag > AXIS_MAX) mag = 32'(AXIS_MAX);
    return AXIS_W'(mag);
  endfunction

  // One register write; the local copy follows once the transfer has happened.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEAD_ZONE: dz_shadow = data;
      REG_GAIN: gain_shadow = data;
      REG_EXPONENT: exp_shadow = data[EXP_IN_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all three registers; unused exponent data bits carry noise.
  task automatic set_curve(input logic [CFG_DATA_W-1:0] dz, input logic [GAIN_W-1:0] g,
                           input logic [EXP_IN_W-1:0] ex);
    write_reg(REG_DEAD_ZONE, dz);
    write_reg(REG_GAIN, g);
    write_reg(REG_EXPONENT, {(CFG_DATA_W-EXP_IN_W)'($urandom), ex});
    @(negedge clk);
  endtask

  // Random setting that leans on the extremes of each register.
  task automatic pick_curve();
    logic [CFG_DATA_W-1:0] dz;
    logic [GAIN_W-1:0] g;
    logic [EXP_IN_W-1:0] ex;
    case ($urandom_range(0, 4))
      0: dz = '0;
      1: dz = '1;
      default: dz = CFG_DATA_W'($urandom_range(0, 24576));
    endcase
    case ($urandom_range(0, 5))
      0: g = GAIN_W'(1);
      1: g = '1;
      2: g = '0;
      default: g = GAIN_W'($urandom);
    endcase
    if ($urandom_range(0, 3) == 0) ex = EXP_IN_W'($urandom);
    else ex = EXP_IN_W'($urandom_range(1, MAX_EXPONENT));
    set_curve(dz, g, ex);
  endtask

  // Waits until every sample is through and the pipeline has settled.
  task automatic wait_idle();
    @(negedge clk);
    while (axis_pending_q.size() != 0 || in_valid || drive_expect_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Sample driver: bursts of transfers with random gaps, payload held while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) drive_expect_q.push_back(shape_axis(in_axis_value));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (axis_pending_q.size() != 0 && !sender_hold) begin
          in_valid <= 1'b1;
          in_axis_value <= axis_pending_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(0, 15);
            gap_left = (burst_left >= 40) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: stall pattern is redrawn when its span runs out, plus a long hold on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      stall_tick++;
      if (stall_span == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_span = $urandom_range(16, 96);
      end else begin
        stall_span--;
      end
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
        STALL_PERIODIC: out_stall <= (stall_tick % 3 == 0);
        default: out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // Result checker: each transfer is compared against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (drive_expect_q.size() == 0) begin
        error_cnt++;
        if (error_cnt <= REPORT_LIMIT)
          $display("ERROR: result %0d drive_value %0d arrived with nothing expected",
                   results_seen, out_drive_value);
      end else begin
        drive_want = drive_expect_q.pop_front();
        if (out_drive_value !== drive_want) begin
          error_cnt++;
          if (error_cnt <= REPORT_LIMIT)
            $display("ERROR: result %0d drive_value expected %0d, got %0d",
                     results_seen, drive_want, out_drive_value);
        end
      end
    end
  end

  // Watchdog on stretches with no transfer on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setting: linear curve with unity gain, field extremes.
    axis_pending_q.push_back('0);
    axis_pending_q.push_back(16'sd1);
    axis_pending_q.push_back(-16'sd1);
    axis_pending_q.push_back(AXIS_MAX);
    axis_pending_q.push_back(AXIS_MIN);
    wait_idle();

    // A write to the unused index must leave the curve alone.
    write_reg(REG_SPARE, '1);
    @(negedge clk);
    axis_pending_q.push_back(16'sh5555);
    axis_pending_q.push_back(16'shAAAA);
    wait_idle();

    // Quarter dead zone, gain two, cube: exact zero and exact full-scale boundaries.
    set_curve(16'd8192, 16'd8192, 4'd3);
    axis_pending_q.push_back(16'sd4096);
    axis_pending_q.push_back(-16'sd4096);
    axis_pending_q.push_back(16'sd4097);
    axis_pending_q.push_back(16'sd20480);
    axis_pending_q.push_back(-16'sd20480);
    axis_pending_q.push_back(16'sd20479);
    wait_idle();

    // Zero gain and zero exponent: output stays at zero.
    set_curve(16'd0, 16'd0, 4'd0);
    axis_pending_q.push_back(AXIS_MAX);
    axis_pending_q.push_back(AXIS_MIN);
    wait_idle();

    // Largest dead zone and gain, exponent above the supported maximum.
    set_curve('1, '1, 4'd15);
    axis_pending_q.push_back(AXIS_MAX);
    axis_pending_q.push_back(AXIS_MIN);
    axis_pending_q.push_back(16'sd5000);
    axis_pending_q.push_back(-16'sd6000);
    wait_idle();

    // Highest supported power.
    set_curve(16'd0, 16'd4096, 4'd8);
    axis_pending_q.push_back(16'sd30000);
    axis_pending_q.push_back(-16'sd12345);
    axis_pending_q.push_back(16'sh4000);
    wait_idle();

    // Random settings, each followed by a run of random samples.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick_curve();
      for (int n = 0; n < PHASE_ITEMS; n++) axis_pending_q.push_back(pick_axis());
      if (ph == 2) begin
        hold_req = 1'b1;
      end
      if (ph == 5) begin
        while (axis_pending_q.size() > PHASE_ITEMS / 2) @(negedge clk);
        sender_hold = 1'b1;
        while (in_valid || drive_expect_q.size() != 0) @(negedge clk);
        sender_hold = 1'b0;
      end
      wait_idle();
    end

    if (error_cnt == 0 && drive_expect_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* axis_deadzone_power_curve.f */
+incdir+src
src/axdz_pkg.sv
src/axis_deadzone_power_curve.sv
tb/axis_deadzone_power_curve_tb.sv
